>>> sv/mr16_pkg.sv
`timescale 1ns / 1ps

package mr16_pkg;

    localparam int DATA_WORDS = 256;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);
    localparam int RF_DEPTH   = 8;
    localparam int RF_AW      = $clog2(RF_DEPTH);

    localparam logic [31:0] ADDR_LIMIT = 32'(DATA_WORDS);
    localparam logic [8:0]  LOAD_LIMIT = 9'(DATA_WORDS);

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_J     = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    localparam logic [2:0] FUNCT_ADD = 3'd0;
    localparam logic [2:0] FUNCT_SUB = 3'd2;
    localparam logic [2:0] FUNCT_AND = 3'd4;
    localparam logic [2:0] FUNCT_OR  = 3'd5;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_FUNCT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_ADDR   = 2'd2;
    localparam logic [1:0] STATUS_BAD_OPCODE = 2'd3;

    // Result of one request; rval is the write value, a load fills it in M
    typedef struct packed {
        logic             rw;
        logic [RF_AW-1:0] ridx;
        logic [31:0]      rval;
        logic             is_load;
        logic             mw;
        logic [7:0]       maddr;
        logic [31:0]      alu;
        logic             zf;
        logic             br;
        logic             jt;
        logic [7:0]       jtarget;
        logic [1:0]       status;
    } ex_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [DMEM_AW-1:0] addr;
        logic [31:0]        wdata;
    } dreq_t;

endpackage

>>> sv/mr16_regfile.sv
`timescale 1ns / 1ps

module mr16_regfile
    import mr16_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [RF_AW-1:0] rd_addr_a,
    input  logic [RF_AW-1:0] rd_addr_b,
    input  logic             wr_en,
    input  logic [RF_AW-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    output logic [31:0]      a_data,
    output logic [31:0]      b_data
);

    logic [31:0]         rf_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] vld_reg;
    logic [31:0]         a_reg;
    logic [31:0]         b_reg;
    logic [31:0]         a_next;
    logic [31:0]         b_next;

    // write-through: a read on the same edge as a write sees the new value
    always_comb
    begin
        a_next = vld_reg[rd_addr_a] ? rf_mem[rd_addr_a] : '0;
        b_next = vld_reg[rd_addr_b] ? rf_mem[rd_addr_b] : '0;
        if (wr_en && (wr_addr == rd_addr_a))
        begin
            a_next = wr_data;
        end
        if (wr_en && (wr_addr == rd_addr_b))
        begin
            b_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign a_data = a_reg;
    assign b_data = b_reg;

endmodule

>>> sv/mr16_dmem.sv
`timescale 1ns / 1ps

module mr16_dmem
    import mr16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_en,
    input  dreq_t       req,
    output logic [31:0] rdata
);

    logic [31:0]           mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] vld_reg;
    logic [31:0]           rdata_reg;
    logic                  rhit_reg;

    always_ff @(posedge clk)
    begin
        if (req_en && req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req_en && req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    // never-written words read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rhit_reg <= 1'b0;
        end
        else if (req_en)
        begin
            if (req.we)
            begin
                vld_reg[req.addr] <= 1'b1;
            end
            if (req.re)
            begin
                rhit_reg <= vld_reg[req.addr];
            end
        end
    end

    assign rdata = rhit_reg ? rdata_reg : '0;

endmodule

>>> sv/mr16_exec.sv
`timescale 1ns / 1ps

module mr16_exec
    import mr16_pkg::*;
(
    input  logic        cmd,
    input  logic [15:0] iw,
    input  logic [7:0]  la,
    input  logic [31:0] lv,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output ex_t         ex,
    output dreq_t       dreq
);

    logic [3:0]       opcode;
    logic [RF_AW-1:0] rt;
    logic [RF_AW-1:0] rd;
    logic [2:0]       funct;
    logic [31:0]      imm;
    logic [31:0]      sum_imm;
    logic             addr_ok;

    assign opcode  = iw[15:12];
    assign rt      = iw[8:6];
    assign rd      = iw[5:3];
    assign funct   = iw[2:0];
    assign imm     = {{26{iw[5]}}, iw[5:0]};
    assign sum_imm = a + imm;
    assign addr_ok = sum_imm < ADDR_LIMIT;

    always_comb
    begin
        ex         = '0;
        dreq       = '0;
        dreq.wdata = b;
        if (cmd == CMD_LOAD)
        begin
            ex.maddr   = la;
            dreq.addr  = la[DMEM_AW-1:0];
            dreq.wdata = lv;
            if ({1'b0, la} < LOAD_LIMIT)
            begin
                dreq.we = 1'b1;
            end
            else
            begin
                ex.status = STATUS_BAD_ADDR;
            end
        end
        else
        begin
            unique case (opcode)
                OP_RTYPE:
                begin
                    ex.ridx = rd;
                    case (funct)
                        FUNCT_ADD: ex.alu = a + b;
                        FUNCT_SUB: ex.alu = a - b;
                        FUNCT_AND: ex.alu = a & b;
                        FUNCT_OR:  ex.alu = a | b;
                        default:   ex.status = STATUS_BAD_FUNCT;
                    endcase
                    ex.zf = (ex.alu == '0);
                    if (ex.status == STATUS_OK)
                    begin
                        ex.rw   = 1'b1;
                        ex.rval = ex.alu;
                    end
                end
                OP_J:
                begin
                    ex.jt      = 1'b1;
                    ex.jtarget = iw[7:0];
                end
                OP_ADDI:
                begin
                    ex.ridx = rt;
                    ex.alu  = sum_imm;
                    ex.zf   = (sum_imm == '0);
                    ex.rw   = 1'b1;
                    ex.rval = sum_imm;
                end
                OP_BEQ:
                begin
                    ex.ridx = rt;
                    ex.alu  = a - b;
                    ex.zf   = (ex.alu == '0);
                    ex.br   = ex.zf;
                end
                OP_LW, OP_SW:
                begin
                    ex.ridx   = rt;
                    ex.alu    = sum_imm;
                    ex.zf     = (sum_imm == '0);
                    ex.maddr  = sum_imm[7:0];
                    dreq.addr = sum_imm[DMEM_AW-1:0];
                    if (!addr_ok)
                    begin
                        ex.status = STATUS_BAD_ADDR;
                    end
                    else if (opcode == OP_LW)
                    begin
                        ex.rw      = 1'b1;
                        ex.is_load = 1'b1;
                        dreq.re    = 1'b1;
                    end
                    else
                    begin
                        ex.mw   = 1'b1;
                        dreq.we = 1'b1;
                    end
                end
                default:
                begin
                    ex.status = STATUS_BAD_OPCODE;
                end
            endcase
        end
    end

endmodule

>>> sv/mini_risc16_execute_unit.sv
`timescale 1ns / 1ps
// A result passes the input/operand register, the execute register (with data memory
// read) and the output register before it is valid.
// Throughput: one request per cycle while out_ready holds; back-to-back dependences are forwarded, no hazard stalls.
// Reset: clears the pipeline, and the register file and data memory read as zero
// until written (per-entry valid flops, cleared at once).
module mini_risc16_execute_unit
    import mr16_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [15:0]        instruction_word,
    input  logic [7:0]         load_address,
    input  logic signed [31:0] load_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               reg_write,
    output logic [2:0]         reg_index,
    output logic signed [31:0] reg_value,
    output logic               mem_write,
    output logic [7:0]         mem_address,
    output logic signed [31:0] alu_value,
    output logic               zero_flag,
    output logic               branch_taken,
    output logic               jump_taken,
    output logic [7:0]         jump_target,
    output logic [1:0]         status
);

    logic        x_valid_reg;
    logic        x_cmd_reg;
    logic [15:0] x_iw_reg;
    logic [7:0]  x_la_reg;
    logic [31:0] x_lv_reg;
    logic        m_valid_reg;
    ex_t         m_ex_reg;
    logic        o_valid_reg;
    ex_t         o_ex_reg;

    logic        in_fire;
    logic        x_adv;
    logic        m_adv;
    logic        o_free;
    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] dmem_rdata;
    ex_t         x_ex;
    dreq_t       x_dreq;
    ex_t         m_fin;

    assign o_free   = !o_valid_reg || out_ready;
    assign m_adv    = m_valid_reg && o_free;
    assign x_adv    = x_valid_reg && (!m_valid_reg || m_adv);
    assign in_ready = !x_valid_reg || x_adv;
    assign in_fire  = in_valid && in_ready;

    // loads pick up memory data in the M stage
    always_comb
    begin
        m_fin = m_ex_reg;
        if (m_ex_reg.is_load)
        begin
            m_fin.rval = dmem_rdata;
        end
    end

    mr16_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_addr_a (instruction_word[11:9]),
        .rd_addr_b (instruction_word[8:6]),
        .wr_en     (m_adv && m_fin.rw),
        .wr_addr   (m_fin.ridx),
        .wr_data   (m_fin.rval),
        .a_data    (rf_a),
        .b_data    (rf_b)
    );

    // forward the pending write of the instruction one ahead
    always_comb
    begin
        op_a = rf_a;
        op_b = rf_b;
        if (m_valid_reg && m_fin.rw && (m_fin.ridx == x_iw_reg[11:9]))
        begin
            op_a = m_fin.rval;
        end
        if (m_valid_reg && m_fin.rw && (m_fin.ridx == x_iw_reg[8:6]))
        begin
            op_b = m_fin.rval;
        end
    end

    mr16_exec u_exec (
        .cmd  (x_cmd_reg),
        .iw   (x_iw_reg),
        .la   (x_la_reg),
        .lv   (x_lv_reg),
        .a    (op_a),
        .b    (op_b),
        .ex   (x_ex),
        .dreq (x_dreq)
    );

    mr16_dmem u_dmem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_en (x_adv),
        .req    (x_dreq),
        .rdata  (dmem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_cmd_reg <= command;
            x_iw_reg  <= instruction_word;
            x_la_reg  <= load_address;
            x_lv_reg  <= $unsigned(load_value);
        end
        if (x_adv)
        begin
            m_ex_reg <= x_ex;
        end
        if (m_adv)
        begin
            o_ex_reg <= m_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                x_valid_reg <= 1'b1;
            end
            else if (x_adv)
            begin
                x_valid_reg <= 1'b0;
            end
            if (x_adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_adv)
            begin
                m_valid_reg <= 1'b0;
            end
            if (m_adv)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = o_valid_reg;
    assign reg_write    = o_ex_reg.rw;
    assign reg_index    = o_ex_reg.ridx;
    assign reg_value    = $signed(o_ex_reg.rval);
    assign mem_write    = o_ex_reg.mw;
    assign mem_address  = o_ex_reg.maddr;
    assign alu_value    = $signed(o_ex_reg.alu);
    assign zero_flag    = o_ex_reg.zf;
    assign branch_taken = o_ex_reg.br;
    assign jump_taken   = o_ex_reg.jt;
    assign jump_target  = o_ex_reg.jtarget;
    assign status       = o_ex_reg.status;

endmodule
